FILE: rtl/core/fpnf_pkg.sv
// Package for the feature preserving normal filter: fixed widths,
// sequencer states and small arithmetic helpers.
// No dependencies.
package fpnf_pkg;

  localparam int COMP_BITS = 16;
  localparam int FRAC      = COMP_BITS - 1;
  localparam int ACC_BITS  = 56;
  localparam int NORM_BITS = 30;
  localparam int DOT_BITS  = 35;
  localparam int W_BITS    = 35;
  localparam int SQ_BITS   = 62;
  localparam int ROOT_BITS = 63;
  localparam int DIV_BITS  = 46;

  localparam logic [15:0] THRESHOLD_RESET = 16'sd16384;

  localparam logic [2:0] ADDR_THRESHOLD = 3'd0;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DOT_X,
    ST_DOT_Y,
    ST_DOT_Z,
    ST_DIFF,
    ST_SQUARE,
    ST_ACC_LO,
    ST_ACC_HI,
    ST_MAG,
    ST_SHIFT,
    ST_SQ,
    ST_SQRT,
    ST_DIV_LOAD,
    ST_DIV,
    ST_EMIT
  } state_t;

  function automatic logic [COMP_BITS-1:0] mag16(input logic signed [COMP_BITS-1:0] v);
    return v[COMP_BITS-1] ? COMP_BITS'(-v) : COMP_BITS'(v);
  endfunction

  function automatic logic [ACC_BITS-1:0] mag56(input logic signed [ACC_BITS-1:0] v);
    return v[ACC_BITS-1] ? ACC_BITS'(-v) : ACC_BITS'(v);
  endfunction

endpackage

FILE: rtl/core/feature_preserving_normal_filter.sv
// Sequencing: each transaction runs the dot product and the threshold difference, then the
//   weighting when its weight is nonzero; the last one adds the normalizing shift k <= 26,
//   the squares, the square root and the three divisions, or goes straight to emit for an
//   all-zero sum, and its result waits for result_ready. A new transaction is taken only in
//   idle; the single 32x32 multiplier serves dot product, squaring and weighting in turn.
// Reset: rst is synchronous and active high; it clears the sums, the sequencer and the
//   output valid, and loads the threshold with 0.5 (16384).
module feature_preserving_normal_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic signed [15:0] center_x,
  input  logic signed [15:0] center_y,
  input  logic signed [15:0] center_z,
  input  logic signed [15:0] neighbor_x,
  input  logic signed [15:0] neighbor_y,
  input  logic signed [15:0] neighbor_z,
  input  logic        last_neighbor,
  output logic        result_valid,
  input  logic        result_ready,
  output logic signed [15:0] filtered_x,
  output logic signed [15:0] filtered_y,
  output logic signed [15:0] filtered_z,
  output logic        degenerate
);

  fpnf_pkg::state_t state, state_next;

  // Configuration
  logic signed [15:0] threshold;

  // Captured transaction
  logic signed [15:0] cx, cy, cz, nx, ny, nz;
  logic last_r;

  // Per-item datapath
  logic signed [fpnf_pkg::DOT_BITS-1:0] dot;
  logic [19:0] dmag;
  logic [fpnf_pkg::W_BITS-1:0] w;
  logic [32:0] lo;
  logic [1:0] axis;

  // Accumulators
  logic signed [fpnf_pkg::ACC_BITS-1:0] sum_x, sum_y, sum_z;

  // Normalization
  logic [fpnf_pkg::ACC_BITS-1:0] mx, my, mz;
  logic [fpnf_pkg::SQ_BITS-1:0] sq;
  logic [fpnf_pkg::SQ_BITS-1:0] rv;
  logic [fpnf_pkg::ROOT_BITS-1:0] root, rbit;
  logic [30:0] norm;
  logic [fpnf_pkg::DIV_BITS-1:0] rem, dsh;
  logic [15:0] quot;
  logic [3:0] cnt;
  logic signed [15:0] res_x, res_y, res_z;
  logic degen_r;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  // Helpers
  logic [15:0] nmag_axis;
  logic nsign_axis;
  logic [fpnf_pkg::ACC_BITS-1:0] m_axis;
  logic signed [fpnf_pkg::ACC_BITS-1:0] sum_axis;
  logic signed [34:0] dot_term;
  logic signed [19:0] dot15;
  logic signed [20:0] dval;
  logic d_pos;
  logic [50:0] contrib_mag;
  logic signed [57:0] contrib, acc_wide;
  logic signed [fpnf_pkg::ACC_BITS-1:0] acc_sat;
  logic shift_more;
  logic [fpnf_pkg::ROOT_BITS-1:0] rtry;
  logic root_ge;
  logic div_ge;
  logic [15:0] q_final;
  logic signed [15:0] q_sat;
  logic sums_zero;
  logic out_free;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr == fpnf_pkg::ADDR_THRESHOLD);
  assign prdata    = (paddr == fpnf_pkg::ADDR_THRESHOLD) ? 32'(threshold) : 32'd0;

  assign mul_p = mul_a * mul_b;
  assign out_free = !result_valid || result_ready;

  always_comb begin
    case (axis)
      fpnf_pkg::AXIS_X: begin
        nmag_axis = fpnf_pkg::mag16(nx);
        nsign_axis = nx[15];
        m_axis = mx;
        sum_axis = sum_x;
      end
      fpnf_pkg::AXIS_Y: begin
        nmag_axis = fpnf_pkg::mag16(ny);
        nsign_axis = ny[15];
        m_axis = my;
        sum_axis = sum_y;
      end
      default: begin
        nmag_axis = fpnf_pkg::mag16(nz);
        nsign_axis = nz[15];
        m_axis = mz;
        sum_axis = sum_z;
      end
    endcase
  end

  // Datapath arithmetic around the multiplier
  always_comb begin
    case (state)
      fpnf_pkg::ST_DOT_X: dot_term = (cx[15] ^ nx[15]) ? -35'(mul_p[31:0]) : 35'(mul_p[31:0]);
      fpnf_pkg::ST_DOT_Y: dot_term = (cy[15] ^ ny[15]) ? -35'(mul_p[31:0]) : 35'(mul_p[31:0]);
      default:            dot_term = (cz[15] ^ nz[15]) ? -35'(mul_p[31:0]) : 35'(mul_p[31:0]);
    endcase
    dot15 = 20'(dot >>> fpnf_pkg::FRAC);
    dval  = 21'(dot15) - 21'(threshold);
    d_pos = !dval[20] && (dval != 21'sd0);
    contrib_mag = {mul_p[33:0], 17'b0} + 51'(lo);
    contrib = nsign_axis ? -58'(contrib_mag) : 58'(contrib_mag);
    acc_wide = 58'(sum_axis) + contrib;
    if (acc_wide > 58'sh7F_FFFF_FFFF_FFFF)
      acc_sat = 56'sh7F_FFFF_FFFF_FFFF;
    else if (acc_wide < -58'sh80_0000_0000_0000)
      acc_sat = 56'sh80_0000_0000_0000;
    else
      acc_sat = 56'(acc_wide);
    shift_more = (mx[55:30] != 26'd0) || (my[55:30] != 26'd0) || (mz[55:30] != 26'd0);
    rtry = root + rbit;
    root_ge = {1'b0, rv} >= rtry;
    div_ge = rem >= dsh;
    q_final = {quot[14:0], div_ge};
    if (sum_axis[55])
      q_sat = (q_final > 16'd32768) ? 16'sh8000 : 16'(17'd0 - {1'b0, q_final});
    else
      q_sat = (q_final > 16'd32767) ? 16'sh7FFF : 16'(q_final);
    sums_zero = (sum_x == '0) && (sum_y == '0) && (sum_z == '0);
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      fpnf_pkg::ST_IDLE:    if (item_valid) state_next = fpnf_pkg::ST_DOT_X;
      fpnf_pkg::ST_DOT_X:   state_next = fpnf_pkg::ST_DOT_Y;
      fpnf_pkg::ST_DOT_Y:   state_next = fpnf_pkg::ST_DOT_Z;
      fpnf_pkg::ST_DOT_Z:   state_next = fpnf_pkg::ST_DIFF;
      fpnf_pkg::ST_DIFF: begin
        if (d_pos) state_next = fpnf_pkg::ST_SQUARE;
        else state_next = last_r ? fpnf_pkg::ST_MAG : fpnf_pkg::ST_IDLE;
      end
      fpnf_pkg::ST_SQUARE:  state_next = fpnf_pkg::ST_ACC_LO;
      fpnf_pkg::ST_ACC_LO:  state_next = fpnf_pkg::ST_ACC_HI;
      fpnf_pkg::ST_ACC_HI: begin
        if (axis != fpnf_pkg::AXIS_Z) state_next = fpnf_pkg::ST_ACC_LO;
        else state_next = last_r ? fpnf_pkg::ST_MAG : fpnf_pkg::ST_IDLE;
      end
      fpnf_pkg::ST_MAG:     state_next = sums_zero ? fpnf_pkg::ST_EMIT : fpnf_pkg::ST_SHIFT;
      fpnf_pkg::ST_SHIFT:   if (!shift_more) state_next = fpnf_pkg::ST_SQ;
      fpnf_pkg::ST_SQ:      if (axis == fpnf_pkg::AXIS_Z) state_next = fpnf_pkg::ST_SQRT;
      fpnf_pkg::ST_SQRT:    if ((rbit >> 2) == '0) state_next = fpnf_pkg::ST_DIV_LOAD;
      fpnf_pkg::ST_DIV_LOAD: state_next = fpnf_pkg::ST_DIV;
      fpnf_pkg::ST_DIV: begin
        if (cnt == 4'd0)
          state_next = (axis == fpnf_pkg::AXIS_Z) ? fpnf_pkg::ST_EMIT : fpnf_pkg::ST_DIV_LOAD;
      end
      fpnf_pkg::ST_EMIT:    if (out_free) state_next = fpnf_pkg::ST_IDLE;
      default:              state_next = fpnf_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and multiplier operands
  always_comb begin
    item_ready = 1'b0;
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (state)
      fpnf_pkg::ST_IDLE:   item_ready = 1'b1;
      fpnf_pkg::ST_DOT_X: begin
        mul_a = 32'(fpnf_pkg::mag16(cx));
        mul_b = 32'(fpnf_pkg::mag16(nx));
      end
      fpnf_pkg::ST_DOT_Y: begin
        mul_a = 32'(fpnf_pkg::mag16(cy));
        mul_b = 32'(fpnf_pkg::mag16(ny));
      end
      fpnf_pkg::ST_DOT_Z: begin
        mul_a = 32'(fpnf_pkg::mag16(cz));
        mul_b = 32'(fpnf_pkg::mag16(nz));
      end
      fpnf_pkg::ST_SQUARE: begin
        mul_a = 32'(dmag);
        mul_b = 32'(dmag);
      end
      fpnf_pkg::ST_ACC_LO: begin
        mul_a = 32'(w[16:0]);
        mul_b = 32'(nmag_axis);
      end
      fpnf_pkg::ST_ACC_HI: begin
        mul_a = 32'(w[34:17]);
        mul_b = 32'(nmag_axis);
      end
      fpnf_pkg::ST_SQ: begin
        mul_a = 32'(m_axis[29:0]);
        mul_b = 32'(m_axis[29:0]);
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fpnf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= fpnf_pkg::THRESHOLD_RESET;
    end else if (cfg_write) begin
      threshold <= pwdata[15:0];
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      cx <= center_x;
      cy <= center_y;
      cz <= center_z;
      nx <= neighbor_x;
      ny <= neighbor_y;
      nz <= neighbor_z;
      last_r <= last_neighbor;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      fpnf_pkg::ST_DOT_X: dot <= dot_term;
      fpnf_pkg::ST_DOT_Y: dot <= dot + dot_term;
      fpnf_pkg::ST_DOT_Z: dot <= dot + dot_term;
      fpnf_pkg::ST_DIFF: begin
        dmag <= dval[19:0];
        axis <= fpnf_pkg::AXIS_X;
      end
      fpnf_pkg::ST_SQUARE: w <= mul_p[fpnf_pkg::W_BITS-1:0];
      fpnf_pkg::ST_ACC_LO: lo <= mul_p[32:0];
      fpnf_pkg::ST_ACC_HI: axis <= axis + 2'd1;
      fpnf_pkg::ST_MAG: begin
        mx <= fpnf_pkg::mag56(sum_x);
        my <= fpnf_pkg::mag56(sum_y);
        mz <= fpnf_pkg::mag56(sum_z);
        axis <= fpnf_pkg::AXIS_X;
        sq <= '0;
        res_x <= '0;
        res_y <= '0;
        res_z <= '0;
        degen_r <= sums_zero;
      end
      fpnf_pkg::ST_SHIFT: begin
        if (shift_more) begin
          mx <= mx >> 1;
          my <= my >> 1;
          mz <= mz >> 1;
        end
      end
      fpnf_pkg::ST_SQ: begin
        sq <= sq + mul_p[fpnf_pkg::SQ_BITS-1:0];
        if (axis == fpnf_pkg::AXIS_Z) begin
          rv <= sq + mul_p[fpnf_pkg::SQ_BITS-1:0];
          root <= '0;
          rbit <= fpnf_pkg::ROOT_BITS'(1) << 62;
          axis <= fpnf_pkg::AXIS_X;
        end else begin
          axis <= axis + 2'd1;
        end
      end
      fpnf_pkg::ST_SQRT: begin
        // One root bit per cycle
        if (root_ge) begin
          rv <= rv - rtry[fpnf_pkg::SQ_BITS-1:0];
          root <= (root >> 1) + rbit;
        end else begin
          root <= root >> 1;
        end
        rbit <= rbit >> 2;
        if ((rbit >> 2) == '0) begin
          if (root_ge) norm <= 31'((root >> 1) + rbit);
          else if ((root >> 1) == '0) norm <= 31'd1;
          else norm <= 31'(root >> 1);
        end
      end
      fpnf_pkg::ST_DIV_LOAD: begin
        rem <= {m_axis[29:0], 15'b0} + fpnf_pkg::DIV_BITS'(norm >> 1);
        dsh <= {norm, 15'b0};
        cnt <= 4'd15;
        quot <= '0;
      end
      fpnf_pkg::ST_DIV: begin
        // Restoring division, one quotient bit per cycle
        if (div_ge) rem <= rem - dsh;
        dsh <= dsh >> 1;
        quot <= q_final;
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          case (axis)
            fpnf_pkg::AXIS_X: res_x <= q_sat;
            fpnf_pkg::AXIS_Y: res_y <= q_sat;
            default:          res_z <= q_sat;
          endcase
          axis <= axis + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // Accumulators: add on the high partial product, clear on emit
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
    end else if (state == fpnf_pkg::ST_ACC_HI) begin
      case (axis)
        fpnf_pkg::AXIS_X: sum_x <= acc_sat;
        fpnf_pkg::AXIS_Y: sum_y <= acc_sat;
        default:          sum_z <= acc_sat;
      endcase
    end else if (state == fpnf_pkg::ST_EMIT && out_free) begin
      sum_x <= '0;
      sum_y <= '0;
      sum_z <= '0;
    end
  end

  // Output register: hold the result until it is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == fpnf_pkg::ST_EMIT && out_free) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == fpnf_pkg::ST_EMIT && out_free) begin
      filtered_x <= res_x;
      filtered_y <= res_y;
      filtered_z <= res_z;
      degenerate <= degen_r;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == fpnf_pkg::ST_DOT_X)
    else $error("accepted transaction did not start the dot product");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    state == fpnf_pkg::ST_EMIT && out_free |=> result_valid && sum_x == '0)
    else $error("emit did not load the output or clear the sums");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && degenerate |-> filtered_x == '0 && filtered_y == '0 && filtered_z == '0)
    else $error("degenerate result carries a nonzero vector");

  a_shift_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == fpnf_pkg::ST_SHIFT |-> (mx != '0) || (my != '0) || (mz != '0))
    else $error("normalizing an all-zero sum");
`endif

endmodule

FILE: bench/fpnf_checker.sv
`timescale 1ns / 100ps
// Checker for the feature preserving normal filter: tracks threshold writes,
// predicts each filtered normal and compares it with the block's output.
// Depends on fpnf_pkg.
module fpnf_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               item_valid,
  input  logic               item_ready,
  input  logic signed [15:0] center_x,
  input  logic signed [15:0] center_y,
  input  logic signed [15:0] center_z,
  input  logic signed [15:0] neighbor_x,
  input  logic signed [15:0] neighbor_y,
  input  logic signed [15:0] neighbor_z,
  input  logic               last_neighbor,
  input  logic               result_valid,
  input  logic               result_ready,
  input  logic signed [15:0] filtered_x,
  input  logic signed [15:0] filtered_y,
  input  logic signed [15:0] filtered_z,
  input  logic               degenerate,
  output int                 errors,
  output int                 pending
);

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               degen;
  } filtered_normal_t;

  localparam longint SUM_MAX = (64'sd1 <<< 55) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< 55);

  logic [15:0] thresh;
  longint acc_x, acc_y, acc_z;
  filtered_normal_t expected_normals[$];

  function automatic longint clamp_sum(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] scale_component(input longint s, input int k,
                                                  input longint unsigned norm);
    longint unsigned m, q;
    m = (s < 0) ? longint'(-s) : longint'(s);
    m = m >> k;
    q = ((m << fpnf_pkg::FRAC) + (norm >> 1)) / norm;
    if (s < 0) begin
      if (q > 64'd32768) q = 64'd32768;
      return 16'(-q);
    end
    if (q > 64'd32767) q = 64'd32767;
    return 16'(q);
  endfunction

  // Fold one neighbor into the weighted sums; on the last one, form the result.
  task automatic absorb_neighbor(output bit emit, output filtered_normal_t res);
    longint dot, diff, w, mx, my, mz, mmax;
    longint unsigned sq, norm;
    int k;
    dot = longint'(center_x) * longint'(neighbor_x) + longint'(center_y) * longint'(neighbor_y)
        + longint'(center_z) * longint'(neighbor_z);
    diff = (dot >>> (2 * fpnf_pkg::FRAC - 15)) - longint'($signed(thresh));
    w = (diff > 0) ? diff * diff : 0;
    acc_x = clamp_sum(acc_x + w * longint'(neighbor_x));
    acc_y = clamp_sum(acc_y + w * longint'(neighbor_y));
    acc_z = clamp_sum(acc_z + w * longint'(neighbor_z));
    emit = last_neighbor;
    res = '0;
    if (!last_neighbor) return;
    mx = (acc_x < 0) ? -acc_x : acc_x;
    my = (acc_y < 0) ? -acc_y : acc_y;
    mz = (acc_z < 0) ? -acc_z : acc_z;
    if (mx == 0 && my == 0 && mz == 0) begin
      res.degen = 1'b1;
    end else begin
      mmax = (mx > my) ? mx : my;
      if (mz > mmax) mmax = mz;
      k = 0;
      while ((mmax >> k) >= (64'sd1 <<< fpnf_pkg::NORM_BITS)) k++;
      sq = longint'((mx >> k) * (mx >> k)) + longint'((my >> k) * (my >> k))
         + longint'((mz >> k) * (mz >> k));
      norm = floor_root(sq);
      if (norm == 0) norm = 1;
      res.x = scale_component(acc_x, k, norm);
      res.y = scale_component(acc_y, k, norm);
      res.z = scale_component(acc_z, k, norm);
    end
    acc_x = 0;
    acc_y = 0;
    acc_z = 0;
  endtask

  always @(posedge clk) begin
    bit emit;
    filtered_normal_t res, want;
    int bad;
    bad = 0;
    if (rst) begin
      thresh = fpnf_pkg::THRESHOLD_RESET;
      acc_x = 0;
      acc_y = 0;
      acc_z = 0;
      expected_normals.delete();
      errors <= 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == fpnf_pkg::ADDR_THRESHOLD)
        thresh = pwdata[15:0];
      if (result_valid && result_ready) begin
        if (expected_normals.size() == 0) begin
          $error("unexpected result transaction");
          bad++;
        end else begin
          want = expected_normals.pop_front();
          if (filtered_x !== want.x) begin
            $error("filtered_x expected %0d got %0d", want.x, filtered_x);
            bad++;
          end
          if (filtered_y !== want.y) begin
            $error("filtered_y expected %0d got %0d", want.y, filtered_y);
            bad++;
          end
          if (filtered_z !== want.z) begin
            $error("filtered_z expected %0d got %0d", want.z, filtered_z);
            bad++;
          end
          if (degenerate !== want.degen) begin
            $error("degenerate expected %0d got %0d", want.degen, degenerate);
            bad++;
          end
        end
      end
      if (item_valid && item_ready) begin
        absorb_neighbor(emit, res);
        if (emit) expected_normals.push_back(res);
      end
      if (bad != 0) errors <= errors + bad;
    end
    pending <= expected_normals.size();
  end
endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Top of the feature preserving normal filter bench: clock, reset, stimulus,
// threshold phases and verdict. Depends on fpnf_pkg, fpnf_checker and the block.
module tb;

  // Drain time before a threshold write and at the end: a last neighbor keeps the
  // block busy through normalization, square root and division.
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 1000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic item_valid = 1'b0;
  logic item_ready;
  logic signed [15:0] center_x = '0, center_y = '0, center_z = '0;
  logic signed [15:0] neighbor_x = '0, neighbor_y = '0, neighbor_z = '0;
  logic last_neighbor = 1'b0;
  logic result_valid;
  logic result_ready = 1'b0;
  logic signed [15:0] filtered_x, filtered_y, filtered_z;
  logic degenerate;
  int errors, pending;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  feature_preserving_normal_filter uut (.*);

  fpnf_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .item_valid, .item_ready, .center_x, .center_y, .center_z,
    .neighbor_x, .neighbor_y, .neighbor_z, .last_neighbor,
    .result_valid, .result_ready, .filtered_x, .filtered_y, .filtered_z,
    .degenerate, .errors, .pending
  );

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("feature_preserving_normal_filter test failed");
      $finish;
    end
  end

  // Receiver: pick a stall pattern at random, at intervals set by the cycle counter - none, coin flip, or long holds.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (cycles % 97 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: result_ready <= 1'b1;
        1: result_ready <= 1'($urandom_range(0, 1));
        default: result_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Push one neighbor transaction; open a gap before each new burst.
  task automatic send_neighbor(input logic [15:0] cx, cy, cz, nx, ny, nz, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    item_valid <= 1'b1;
    center_x <= cx;
    center_y <= cy;
    center_z <= cz;
    neighbor_x <= nx;
    neighbor_y <= ny;
    neighbor_z <= nz;
    last_neighbor <= last;
    do @(posedge clk); while (!item_ready);
    burst_left--;
  endtask

  // Wait for the block to drain, then write the threshold over the config port.
  task automatic write_threshold(input logic [15:0] value);
    item_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= fpnf_pkg::ADDR_THRESHOLD;
    pwdata <= {{16{value[15]}}, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Random unit vector in Q1.15, optionally pulled toward a given direction.
  task automatic pick_normal(input real bx, by, bz, input real spread,
                             output logic [15:0] ox, oy, oz);
    real vx, vy, vz, len;
    do begin
      vx = bx + spread * (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      vy = by + spread * (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      vz = bz + spread * (real'($urandom_range(0, 2000)) - 1000.0) / 1000.0;
      len = $sqrt(vx * vx + vy * vy + vz * vz);
    end while (len < 0.05);
    ox = 16'($rtoi(vx / len * 32767.0));
    oy = 16'($rtoi(vy / len * 32767.0));
    oz = 16'($rtoi(vz / len * 32767.0));
  endtask

  // Mostly well-formed faces (center first among its neighbors), some raw noise.
  task automatic run_faces(input int n_items);
    int sent, len, kind;
    logic [15:0] cx, cy, cz, nx, ny, nz;
    real spread;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      kind = $urandom_range(0, 9);
      spread = real'($urandom_range(0, 100)) / 100.0;
      pick_normal(0.0, 0.0, 0.0, 1.0, cx, cy, cz);
      for (int i = 0; i < len; i++) begin
        if (kind == 0) begin
          send_neighbor(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
        end else begin
          if (i == 0) {nx, ny, nz} = {cx, cy, cz};
          else pick_normal($signed(cx) / 32768.0, $signed(cy) / 32768.0,
                           $signed(cz) / 32768.0, spread, nx, ny, nz);
          send_neighbor(cx, cy, cz, nx, ny, nz, i == len - 1);
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed cases at the reset threshold of one half.
    send_neighbor(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);        // zero sum
    send_neighbor(16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 16'sd0, 1'b1); // +1.0 clip
    send_neighbor(-16'sd32768, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 1'b1);
    send_neighbor(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_neighbor(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send_neighbor(16'sd32767, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0, 1'b1); // no weight
    send_neighbor(16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd32767, 16'sd0, 1'b0);
    send_neighbor(16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd23170, 16'sd23170, 1'b0);
    send_neighbor(16'sd0, 16'sd32767, 16'sd0, 16'sd0, 16'sd23170, -16'sd23170, 1'b1);
    send_neighbor(-16'sd18918, 16'sd18918, -16'sd18918, -16'sd18918, 16'sd18918,
                  -16'sd18918, 1'b0);
    send_neighbor(-16'sd18918, 16'sd18918, -16'sd18918, 16'sd0, 16'sd0, -16'sd32768, 1'b1);
    send_neighbor(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 1'b1);
    run_faces(150);

    // Lowest threshold: every aligned neighbor weighs in; drive one long
    // group of extreme normals into sum saturation.
    write_threshold(16'h8000);
    for (int i = 0; i < 80; i++)
      send_neighbor(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, i == 79);
    run_faces(100);

    // Highest threshold: weights vanish, results mostly degenerate.
    write_threshold(16'h7fff);
    run_faces(80);

    write_threshold(16'h0000);
    run_faces(100);

    write_threshold(16'($urandom));
    run_faces(80);

    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("feature_preserving_normal_filter test passed");
    end else begin
      $display("feature_preserving_normal_filter test failed");
    end
    $finish;
  end
endmodule
